>>> rtl/core/serial_register_access_parser_core_assert.svh
// ----------------------------------------------------------------------------
// serial register access parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SERIAL_REGISTER_ACCESS_PARSER_CORE_ASSERT_SVH
`define SERIAL_REGISTER_ACCESS_PARSER_CORE_ASSERT_SVH

// antecedent implies consequent in the next cycle, skipped while in reset
`define SRAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srap next-cycle check failed");

// same form, also checked while reset is applied
`define SRAP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("srap reset check failed");

`endif

>>> rtl/core/srap_pkg.sv
// ----------------------------------------------------------------------------
// srap_pkg
// shared types, constants and the crc-8 step for the register access parser
// ----------------------------------------------------------------------------
package srap_pkg;

  localparam int REGISTER_COUNT_DEF = 16;

  localparam logic [7:0] START_MASK = 8'h80;
  localparam logic [7:0] INDEX_MASK = 8'h7F;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;
  localparam logic [7:0] CRC_POLY   = 8'h8C;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INDEX,
    PH_DATA_HI,
    PH_DATA_LO,
    PH_WR_CRC,
    PH_RD_CRC
  } phase_t;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       reply_kind;
    logic       last_byte;
  } reply_t;

  // one byte of reflected crc-8, poly 0x8c
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/srap_regfile.sv
// ----------------------------------------------------------------------------
// srap_regfile
// 16-bit register store, one write and one registered read port,
// per-entry valid bits so reset reads back as zero
// ----------------------------------------------------------------------------
module srap_regfile #(
  parameter int REGISTER_COUNT = srap_pkg::REGISTER_COUNT_DEF,
  parameter int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [15:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [15:0]      rd_word
);
  import srap_pkg::*;

  logic [15:0]               mem_r [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld_r;
  logic [15:0]               rd_data_r;
  logic                      rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hit_r <= 1'b0;
    end else if (rd_en) begin
      rd_hit_r <= vld_r[rd_idx];
    end
  end

  // never-written entries read as zero
  assign rd_word = rd_hit_r ? rd_data_r : 16'h0000;

endmodule

>>> rtl/core/srap_reply_q.sv
// ----------------------------------------------------------------------------
// srap_reply_q
// two-entry reply buffer, loaded with a whole two-byte reply at once
// ----------------------------------------------------------------------------
module srap_reply_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srap_pkg::reply_t first_in,
  input  srap_pkg::reply_t second_in,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output srap_pkg::reply_t head
);
  import srap_pkg::*;

  reply_t     head_r, head_nxt;
  reply_t     tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign head      = head_r;
  // room for a full reply once this cycle's pop is counted
  assign room      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      head_nxt = first_in;
      tail_nxt = second_in;
      cnt_nxt  = 2'd2;
    end else if (pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/serial_register_access_parser_core.sv
// flow: a byte sits in the input register for the cycle after its accepting edge and is
//   parsed there; a reply to it is registered in the reply buffer and shows on out_* after that
// throughput: one byte per cycle unless stalled; a reply sends its two bytes in turn, and the
//   input register waits until the reply buffer has room for both bytes
// reset (synchronous, rst_n low): parser idle, crc/index/word cleared, every register reads 0
// ----------------------------------------------------------------------------
// serial_register_access_parser_core
// frame parser for register read/write commands over a byte link, crc-8 checked
// ----------------------------------------------------------------------------
module serial_register_access_parser_core #(
  parameter int REGISTER_COUNT = srap_pkg::REGISTER_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_reply_kind,
  output logic       out_last_byte
);
  import srap_pkg::*;

  localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [7:0] REG_CNT8 = 8'(REGISTER_COUNT);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // parser state
  phase_t     phase_r, phase_nxt;
  logic [IDX_W-1:0] tgt_r, tgt_nxt;
  logic [15:0] word_r, word_nxt;
  logic [7:0]  crc_r, crc_nxt;

  // stage control
  logic       fire;
  logic       room;
  logic       push;
  reply_t     first_reply;
  reply_t     second_reply;
  reply_t     head;
  logic       wr_en;
  logic       rd_en;
  logic [15:0] rd_word;
  logic [6:0] idx;
  logic       idx_ok;
  logic [7:0] crc_upd;

  // the parse stage only runs when a whole reply could be buffered
  assign fire     = in_vld_r && room;
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  assign idx     = in_byte_r[6:0] & INDEX_MASK[6:0];
  assign idx_ok  = ({1'b0, idx} < REG_CNT8);
  assign crc_upd = crc8_step(crc_r, in_byte_r & BYTE_MASK);

  // next state and stage outputs
  always_comb begin
    phase_nxt    = phase_r;
    tgt_nxt      = tgt_r;
    word_nxt     = word_r;
    crc_nxt      = crc_r;
    push         = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    first_reply  = '{tx_byte: in_byte_r, reply_kind: KIND_WRITE, last_byte: 1'b0};
    second_reply = '{tx_byte: crc_r, reply_kind: KIND_WRITE, last_byte: 1'b1};
    if (fire) begin
      case (phase_r)
        PH_IDLE: begin
          // stray bytes without the start bit are dropped
          if ((in_byte_r & START_MASK) != 8'h00) begin
            crc_nxt   = crc8_step(8'h00, in_byte_r);
            phase_nxt = PH_INDEX;
          end
        end
        PH_INDEX: begin
          tgt_nxt = idx[IDX_W-1:0];
          if (!idx_ok) begin
            // index past the register file aborts the frame, crc untouched
            phase_nxt = PH_IDLE;
          end else begin
            rd_en     = 1'b1;
            crc_nxt   = crc_upd;
            phase_nxt = in_byte_r[7] ? PH_DATA_HI : PH_RD_CRC;
          end
        end
        PH_DATA_HI: begin
          word_nxt  = {8'h00, in_byte_r};
          crc_nxt   = crc_upd;
          phase_nxt = PH_DATA_LO;
        end
        PH_DATA_LO: begin
          word_nxt  = {word_r[7:0], in_byte_r};
          crc_nxt   = crc_upd;
          phase_nxt = PH_WR_CRC;
        end
        PH_WR_CRC: begin
          phase_nxt = PH_IDLE;
          if (crc_r == in_byte_r) begin
            // write ack echoes the crc twice
            wr_en = 1'b1;
            push  = 1'b1;
          end
        end
        PH_RD_CRC: begin
          phase_nxt = PH_IDLE;
          if (crc_r == in_byte_r) begin
            push         = 1'b1;
            first_reply  = '{tx_byte: rd_word[15:8], reply_kind: KIND_READ, last_byte: 1'b0};
            second_reply = '{tx_byte: rd_word[7:0], reply_kind: KIND_READ, last_byte: 1'b1};
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tgt_r   <= '0;
      word_r  <= 16'h0000;
      crc_r   <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      tgt_r   <= tgt_nxt;
      word_r  <= word_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // register file, read is fetched at the index byte so it is ready by the crc byte
  srap_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT),
    .IDX_W         (IDX_W)
  ) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_idx (tgt_r),
    .wr_data(word_r),
    .rd_en  (rd_en),
    .rd_idx (idx[IDX_W-1:0]),
    .rd_word(rd_word)
  );

  // reply buffer decouples the parser from the transmit side
  srap_reply_q u_reply_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .first_in (first_reply),
    .second_in(second_reply),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_tx_byte    = head.tx_byte;
  assign out_reply_kind = head.reply_kind;
  assign out_last_byte  = head.last_byte;

endmodule

>>> rtl/core/srap_checker.sv
// ----------------------------------------------------------------------------
// srap_checker
// port-level checks on the reply channel of the parser core
// ----------------------------------------------------------------------------
`include "serial_register_access_parser_core_assert.svh"

module srap_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_reply_kind,
  input logic       out_last_byte
);

  // a stalled reply item stays put
  `SRAP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_tx_byte) && $stable(out_reply_kind) && $stable(out_last_byte))

  // the second byte of a reply is buffered and follows at once
  `SRAP_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !out_last_byte, out_valid && out_last_byte)

  // both bytes of a reply carry the same kind
  `SRAP_ASSERT_NEXT(a_pair_kind, clk, rst_n, out_valid && out_ready && !out_last_byte, out_reply_kind == $past(out_reply_kind))

  // reset empties the reply buffer
  `SRAP_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind serial_register_access_parser_core srap_port_checker u_srap_checker (.*);
